// ----- rtl/fc32_pkg.sv -----
// fc32_pkg: shared types, constants and the byte-wide crc-32 update
// for the frame checker; no dependencies
package fc32_pkg;

    localparam int POSITION_BITS_DEF = 34;

    localparam int HEADER_BYTES = 10;
    localparam int CRC_BYTES    = 4;
    localparam int MIN_FRAME    = HEADER_BYTES + CRC_BYTES;

    localparam int REG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [31:0] MAGIC_RESET     = 32'd0;
    localparam logic [7:0]  VERSION_RESET   = 8'd1;
    localparam logic [7:0]  TYPE_LO_RESET   = 8'd1;
    localparam logic [7:0]  TYPE_HI_RESET   = 8'd255;
    localparam logic [31:0] MAX_FRAME_RESET = 32'd4096;

    typedef enum logic [1:0] {
        FAULT_NONE,
        FAULT_MAGIC,
        FAULT_VERSION,
        FAULT_TYPE
    } fault_t;

    typedef enum logic [3:0] {
        STAT_OK        = 4'd0,
        STAT_SHORT     = 4'd1,
        STAT_MAGIC     = 4'd2,
        STAT_VERSION   = 4'd3,
        STAT_TYPE      = 4'd4,
        STAT_TOO_LARGE = 4'd5,
        STAT_TRUNCATED = 4'd6,
        STAT_TRAILING  = 4'd7,
        STAT_CRC       = 4'd8
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_MAGIC     = 3'd0,
        REG_VERSION   = 3'd1,
        REG_TYPE_LO   = 3'd2,
        REG_TYPE_HI   = 3'd3,
        REG_MAX_FRAME = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  type_lo;
        logic [7:0]  type_hi;
        logic [31:0] max_frame;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  msg_type;
        logic [31:0] length;
    } res_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/fc32_ifs.sv -----
// fc32_rx_if and fc32_res_if: valid/ready channels of the frame checker
// depends on nothing
interface fc32_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface fc32_res_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_status;
    logic [7:0]  message_type;
    logic [31:0] payload_length;

    modport source (output valid, output item_kind, output payload_byte,
                    output frame_status, output message_type, output payload_length,
                    input ready);
    modport sink (input valid, input item_kind, input payload_byte,
                  input frame_status, input message_type, input payload_length,
                  output ready);
endinterface

// ----- rtl/fc32_cfg.sv -----
// fc32_cfg: configuration registers of the frame checker
// depends on fc32_pkg
module fc32_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [fc32_pkg::REG_INDEX_BITS-1:0] wr_index,
    input  logic [fc32_pkg::CFG_DATA_BITS-1:0]  wr_data,
    output fc32_pkg::cfg_t                      cfg
);
    import fc32_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_MAGIC:     cfg_next.magic     = wr_data;
                REG_VERSION:   cfg_next.version   = wr_data[7:0];
                REG_TYPE_LO:   cfg_next.type_lo   = wr_data[7:0];
                REG_TYPE_HI:   cfg_next.type_hi   = wr_data[7:0];
                REG_MAX_FRAME: cfg_next.max_frame = wr_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic     <= MAGIC_RESET;
            cfg_reg.version   <= VERSION_RESET;
            cfg_reg.type_lo   <= TYPE_LO_RESET;
            cfg_reg.type_hi   <= TYPE_HI_RESET;
            cfg_reg.max_frame <= MAX_FRAME_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/fc32_judge.sv -----
// fc32_judge: final frame status from size, header fault, frame limit and checksum
// depends on fc32_pkg
module fc32_judge #(
    parameter int CW = 35
) (
    input  logic [CW-1:0]     size,
    input  logic [CW-1:0]     frame_total,
    input  fc32_pkg::fault_t  fault,
    input  logic [31:0]       max_frame,
    input  logic [31:0]       crc,
    input  logic [31:0]       last4,
    output fc32_pkg::status_t status
);
    import fc32_pkg::*;

    always_comb
    begin
        priority if (size < CW'(MIN_FRAME))
            status = STAT_SHORT;
        else if (fault == FAULT_MAGIC)
            status = STAT_MAGIC;
        else if (fault == FAULT_VERSION)
            status = STAT_VERSION;
        else if (fault == FAULT_TYPE)
            status = STAT_TYPE;
        else if (frame_total > CW'(max_frame))
            status = STAT_TOO_LARGE;
        else if (size < frame_total)
            status = STAT_TRUNCATED;
        else if (size != frame_total)
            status = STAT_TRAILING;
        else if ((crc ^ CRC_INIT) != last4)
            status = STAT_CRC;
        else
            status = STAT_OK;
    end

endmodule

// ----- rtl/fc32_track.sv -----
// fc32_track: per-buffer state (position, header fields, crc, last bytes)
// and the result of one byte; depends on fc32_pkg and fc32_judge
module fc32_track #(
    parameter int POSITION_BITS = fc32_pkg::POSITION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic [7:0]     data_byte,
    input  logic           end_of_buffer,
    input  fc32_pkg::cfg_t cfg,
    output fc32_pkg::res_t res
);
    import fc32_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int CW = ((PB > 33) ? PB : 33) + 1;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    logic [PB-1:0] pos_reg,   pos_next;
    fault_t        fault_reg, fault_next;
    logic [31:0]   hdr_reg,   hdr_next;
    logic [7:0]    type_reg,  type_next;
    logic [31:0]   len_reg,   len_next;
    logic [31:0]   crc_reg,   crc_next;
    logic [31:0]   last4_reg, last4_next;

    logic [CW-1:0] pos_ext;
    logic [CW-1:0] body_end;
    logic [CW-1:0] size;
    logic [CW-1:0] frame_total;
    logic          in_body;
    logic [1:0]    len_lane;
    status_t       status;

    always_comb
    begin
        hdr_next   = hdr_reg;
        fault_next = fault_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        len_lane   = pos_reg[1:0] - 2'd2;

        priority if (pos_reg < PB'(4))
        begin
            hdr_next = hdr_reg | ({24'd0, data_byte} << {pos_reg[1:0], 3'b000});
            if (pos_reg[1:0] == 2'd3 && fault_reg == FAULT_NONE && hdr_next != cfg.magic)
                fault_next = FAULT_MAGIC;
        end
        else if (pos_reg == PB'(4))
        begin
            if (fault_reg == FAULT_NONE && data_byte != cfg.version)
                fault_next = FAULT_VERSION;
        end
        else if (pos_reg == PB'(5))
        begin
            type_next = data_byte;
            if (fault_reg == FAULT_NONE && (data_byte == 8'd0 || data_byte < cfg.type_lo
                || data_byte > cfg.type_hi))
                fault_next = FAULT_TYPE;
        end
        else if (pos_reg < PB'(HEADER_BYTES))
        begin
            len_next = len_reg | ({24'd0, data_byte} << {len_lane, 3'b000});
        end

        pos_ext     = CW'(pos_reg);
        body_end    = CW'(HEADER_BYTES) + CW'(len_next);
        in_body     = pos_ext < body_end;
        size        = pos_ext + CW'(1);
        frame_total = body_end + CW'(CRC_BYTES);

        if (pos_reg < PB'(HEADER_BYTES) || in_body)
            crc_next = crc_byte(crc_reg, data_byte);
        last4_next = {data_byte, last4_reg[31:8]};
    end

    fc32_judge #(
        .CW (CW)
    ) u_judge (
        .size        (size),
        .frame_total (frame_total),
        .fault       (fault_next),
        .max_frame   (cfg.max_frame),
        .crc         (crc_next),
        .last4       (last4_next),
        .status      (status)
    );

    always_comb
    begin
        res.valid        = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_byte;
        res.status       = STAT_OK;
        res.msg_type     = type_next;
        res.length       = len_next;
        pos_next         = (pos_reg != POS_MAX) ? pos_reg + PB'(1) : pos_reg;
        if (end_of_buffer)
        begin
            res.valid        = 1'b1;
            res.kind         = KIND_STATUS;
            res.payload_byte = 8'd0;
            res.status       = status;
            pos_next         = '0;
        end
        else if (pos_reg >= PB'(HEADER_BYTES) && in_body)
        begin
            res.valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            fault_reg <= FAULT_NONE;
            hdr_reg   <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            crc_reg   <= CRC_INIT;
            last4_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            if (end_of_buffer)
            begin
                fault_reg <= FAULT_NONE;
                hdr_reg   <= '0;
                type_reg  <= '0;
                len_reg   <= '0;
                crc_reg   <= CRC_INIT;
                last4_reg <= '0;
            end
            else
            begin
                fault_reg <= fault_next;
                hdr_reg   <= hdr_next;
                type_reg  <= type_next;
                len_reg   <= len_next;
                crc_reg   <= crc_next;
                last4_reg <= last4_next;
            end
        end
    end

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && end_of_buffer |=> pos_reg == '0 && fault_reg == FAULT_NONE)
        else $error("state not cleared after last beat");

    a_crc_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == '0 |-> crc_reg == CRC_INIT && len_reg == '0)
        else $error("crc or length not fresh at buffer start");

    a_pos_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !end_of_buffer |=> pos_reg != '0)
        else $error("position wrapped within a buffer");

    a_payload_place: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == KIND_PAYLOAD |-> pos_reg >= PB'(HEADER_BYTES)
            && res.status == STAT_OK)
        else $error("payload beat from header position");

endmodule

// ----- rtl/frame_checker_crc32_unit.sv -----
// frame_checker_crc32_unit: a result beat shows the cycle after its byte is accepted
// throughput 1 byte per cycle; byte-wide crc update and header checks sit between
// the state registers and the result register; rx.ready drops while a result beat waits
// reset: asynchronous, clears per-buffer state, result valid and sets config defaults
// depends on fc32_pkg, fc32_ifs, fc32_cfg, fc32_track
module frame_checker_crc32_unit #(
    parameter int POSITION_BITS = fc32_pkg::POSITION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    fc32_rx_if.sink                             rx,
    fc32_res_if.source                          res,
    input  logic                                wr_en,
    input  logic [fc32_pkg::REG_INDEX_BITS-1:0] wr_index,
    input  logic [fc32_pkg::CFG_DATA_BITS-1:0]  wr_data
);
    import fc32_pkg::*;

    cfg_t        cfg;
    res_t        trk_res;
    logic        advance;
    logic        rx_ready;
    logic        valid_reg, valid_next;
    kind_t       kind_reg;
    logic [7:0]  byte_reg;
    status_t     status_reg;
    logic [7:0]  type_reg;
    logic [31:0] len_reg;

    assign rx_ready = !valid_reg || res.ready;
    assign rx.ready = rx_ready;
    assign advance  = rx.valid && rx_ready;

    fc32_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    fc32_track #(
        .POSITION_BITS (POSITION_BITS)
    ) u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .data_byte     (rx.data_byte),
        .end_of_buffer (rx.end_of_buffer),
        .cfg           (cfg),
        .res           (trk_res)
    );

    always_comb
    begin
        if (advance)
            valid_next = trk_res.valid;
        else
            valid_next = valid_reg && !res.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && trk_res.valid)
        begin
            kind_reg   <= trk_res.kind;
            byte_reg   <= trk_res.payload_byte;
            status_reg <= trk_res.status;
            type_reg   <= trk_res.msg_type;
            len_reg    <= trk_res.length;
        end
    end

    assign res.valid          = valid_reg;
    assign res.item_kind      = kind_reg;
    assign res.payload_byte   = byte_reg;
    assign res.frame_status   = status_reg;
    assign res.message_type   = type_reg;
    assign res.payload_length = len_reg;

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res.ready |-> !rx.ready)
        else $error("input taken while result beat stalled");

    a_new_beat: assert property (@(posedge clk) disable iff (!rst_n)
        advance && trk_res.valid |=> valid_reg)
        else $error("result beat lost");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && kind_reg == KIND_STATUS |-> byte_reg == 8'd0)
        else $error("status beat carries payload byte");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for frame_checker_crc32_unit, random framed buffers
// with a scoreboard that predicts payload and status beats; needs fc32_pkg and fc32_ifs
module tb_top;
    import fc32_pkg::*;

    localparam int POS_BITS = POSITION_BITS_DEF;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        kind_t       kind;
        logic [7:0]  pbyte;
        status_t     status;
        logic [7:0]  mtype;
        logic [31:0] plen;
    } beat_t;

    class frame_verdict_board;
        cfg_t                cfg;
        logic [POS_BITS-1:0] pos;
        fault_t              fault;
        logic [31:0]         hdr_word;
        logic [7:0]          type_seen;
        logic [31:0]         len_seen;
        logic [31:0]         crc_reg;
        logic [31:0]         last_word;
        beat_t               expected_beats[$];
        int unsigned         errors;

        function new();
            cfg.magic = MAGIC_RESET;
            cfg.version = VERSION_RESET;
            cfg.type_lo = TYPE_LO_RESET;
            cfg.type_hi = TYPE_HI_RESET;
            cfg.max_frame = MAX_FRAME_RESET;
            errors = 0;
            clear_buffer();
        endfunction

        static function logic [31:0] crc_after(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            repeat (8) r = {1'b0, r[31:1]} ^ (r[0] ? CRC_POLY : 32'd0);
            return r;
        endfunction

        function void clear_buffer();
            pos = '0;
            fault = FAULT_NONE;
            hdr_word = '0;
            type_seen = '0;
            len_seen = '0;
            crc_reg = CRC_INIT;
            last_word = '0;
        endfunction

        function void set_reg(reg_index_t idx, logic [31:0] v);
            case (idx)
                REG_MAGIC:     cfg.magic = v;
                REG_VERSION:   cfg.version = v[7:0];
                REG_TYPE_LO:   cfg.type_lo = v[7:0];
                REG_TYPE_HI:   cfg.type_hi = v[7:0];
                REG_MAX_FRAME: cfg.max_frame = v;
                default:       ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

        function void note_byte(logic [7:0] b, logic is_last);
            logic [63:0] p;
            logic [63:0] body_end;
            logic [63:0] size;
            logic [63:0] frame_total;
            status_t     st;
            beat_t       nb;
            p = 64'(pos);
            if (p < 64'd4)
            begin
                hdr_word |= {24'd0, b} << (8 * p[1:0]);
                if (p == 64'd3 && fault == FAULT_NONE && hdr_word != cfg.magic)
                    fault = FAULT_MAGIC;
            end
            else if (p == 64'd4)
            begin
                if (fault == FAULT_NONE && b != cfg.version)
                    fault = FAULT_VERSION;
            end
            else if (p == 64'd5)
            begin
                type_seen = b;
                if (fault == FAULT_NONE && (b == 8'd0 || b < cfg.type_lo || b > cfg.type_hi))
                    fault = FAULT_TYPE;
            end
            else if (p < 64'(HEADER_BYTES))
            begin
                len_seen |= {24'd0, b} << (8 * (p[3:0] - 4'd6));
            end

            body_end = 64'(HEADER_BYTES) + 64'(len_seen);
            if (p < 64'(HEADER_BYTES) || p < body_end)
                crc_reg = crc_after(crc_reg, b);
            last_word = {b, last_word[31:8]};

            if (is_last)
            begin
                size = p + 64'd1;
                frame_total = body_end + 64'(CRC_BYTES);
                if (size < 64'(MIN_FRAME))
                    st = STAT_SHORT;
                else if (fault == FAULT_MAGIC)
                    st = STAT_MAGIC;
                else if (fault == FAULT_VERSION)
                    st = STAT_VERSION;
                else if (fault == FAULT_TYPE)
                    st = STAT_TYPE;
                else if (frame_total > 64'(cfg.max_frame))
                    st = STAT_TOO_LARGE;
                else if (size < frame_total)
                    st = STAT_TRUNCATED;
                else if (size != frame_total)
                    st = STAT_TRAILING;
                else if (~crc_reg != last_word)
                    st = STAT_CRC;
                else
                    st = STAT_OK;
                nb = '{kind: KIND_STATUS, pbyte: 8'd0, status: st,
                       mtype: type_seen, plen: len_seen};
                expected_beats.insert(expected_beats.size(), nb);
                clear_buffer();
                return;
            end

            pos = (pos != POS_MAX) ? pos + 1'b1 : pos;
            if (p >= 64'(HEADER_BYTES) && p < body_end)
            begin
                nb = '{kind: KIND_PAYLOAD, pbyte: b, status: STAT_OK,
                       mtype: type_seen, plen: len_seen};
                expected_beats.insert(expected_beats.size(), nb);
            end
        endfunction

        function void check_beat(logic kind, logic [7:0] pbyte, logic [3:0] status,
                                 logic [7:0] mtype, logic [31:0] plen);
            beat_t e;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: kind %0d status %0d", kind, status);
                errors++;
                return;
            end
            e = expected_beats.pop_front();
            if (kind !== e.kind)
            begin
                $error("item_kind: expected %0d, got %0d", e.kind, kind);
                errors++;
            end
            if (pbyte !== e.pbyte)
            begin
                $error("payload_byte: expected %0h, got %0h", e.pbyte, pbyte);
                errors++;
            end
            if (status !== e.status)
            begin
                $error("frame_status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (mtype !== e.mtype)
            begin
                $error("message_type: expected %0h, got %0h", e.mtype, mtype);
                errors++;
            end
            if (plen !== e.plen)
            begin
                $error("payload_length: expected %0h, got %0h", e.plen, plen);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      wr_en;
    logic [REG_INDEX_BITS-1:0] wr_index;
    logic [CFG_DATA_BITS-1:0]  wr_data;
    logic [7:0]                frame_bytes[$];
    int unsigned               stall_cycles;

    fc32_rx_if  rx_ch();
    fc32_res_if res_ch();

    frame_checker_crc32_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx_ch),
        .res      (res_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    frame_verdict_board sb = new();

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 40);
    endfunction

    function automatic void put_header(logic [31:0] magic, logic [7:0] ver, logic [7:0] typ,
                                       logic [31:0] len);
        int i;
        for (i = 0; i < 4; i++)
            frame_bytes.insert(frame_bytes.size(), magic[8*i +: 8]);
        frame_bytes.insert(frame_bytes.size(), ver);
        frame_bytes.insert(frame_bytes.size(), typ);
        for (i = 0; i < 4; i++)
            frame_bytes.insert(frame_bytes.size(), len[8*i +: 8]);
    endfunction

    function automatic void put_payload(logic [31:0] n);
        repeat (n) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
    endfunction

    function automatic void put_crc();
        logic [31:0] c;
        int          i;
        c = CRC_INIT;
        foreach (frame_bytes[k])
            c = frame_verdict_board::crc_after(c, frame_bytes[k]);
        c = ~c;
        for (i = 0; i < 4; i++)
            frame_bytes.insert(frame_bytes.size(), c[8*i +: 8]);
    endfunction

    // some well-formed frames, the rest with one fault each or plain noise
    function automatic void make_buffer();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        logic [7:0]  lo;
        logic [7:0]  typ;
        logic [7:0]  ver;
        logic [7:0]  cand;
        logic [31:0] magic;
        logic [31:0] len;
        frame_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            n = $urandom_range(1, 24);
            put_payload(n);
            return;
        end
        magic = sb.cfg.magic;
        ver = sb.cfg.version;
        lo = (sb.cfg.type_lo == 8'd0) ? 8'd1 : sb.cfg.type_lo;
        if (lo <= sb.cfg.type_hi)
            typ = 8'($urandom_range(lo, sb.cfg.type_hi));
        else
            typ = 8'($urandom_range(1, 255));
        len = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(13, 80))
                                          : 32'($urandom_range(0, 12));

        if (pick >= 45 && pick < 52)
            magic ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
        else if (pick >= 52 && pick < 58)
            ver ^= 8'($urandom_range(1, 255));
        else if (pick >= 58 && pick < 64)
        begin
            typ = 8'd0;
            if ($urandom_range(0, 2) != 0)
            begin
                repeat (8)
                begin
                    cand = 8'($urandom);
                    if (cand < sb.cfg.type_lo || cand > sb.cfg.type_hi)
                        typ = cand;
                end
            end
        end
        else if (pick >= 64 && pick < 70)
            len = $urandom;

        put_header(magic, ver, typ, len);
        if (pick >= 64 && pick < 70)
        begin
            // huge length, only the head of the body goes out
            put_payload(len > 32'd6 ? 32'd6 : len);
            return;
        end
        put_payload(len);
        put_crc();

        if (pick >= 70 && pick < 78)
        begin
            n = $urandom_range(1, 6);
            repeat (n) void'(frame_bytes.pop_back());
        end
        else if (pick >= 78 && pick < 85)
            put_payload($urandom_range(1, 5));
        else if (pick >= 85 && pick < 93)
        begin
            k = $urandom_range(HEADER_BYTES, frame_bytes.size() - 1);
            frame_bytes[k] ^= 8'(1 << $urandom_range(0, 7));
        end
        else if (pick >= 93)
        begin
            n = $urandom_range(1, MIN_FRAME - 1);
            while (frame_bytes.size() > n)
                void'(frame_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic is_last, int unsigned gap);
        if (gap != 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.data_byte <= b;
        rx_ch.end_of_buffer <= is_last;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        sb.note_byte(b, is_last);
    endtask

    task automatic send_buffer();
        bit burst;
        burst = ($urandom_range(0, 3) == 0);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, burst ? 0 : idle_len());
    endtask

    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] v);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic set_phase(int phase);
        case (phase)
            1:
            begin
                write_reg(REG_MAGIC, $urandom);
                write_reg(REG_VERSION, $urandom_range(0, 255));
                write_reg(REG_TYPE_LO, $urandom_range(1, 60));
                write_reg(REG_TYPE_HI, $urandom_range(100, 255));
            end
            2:
            begin
                write_reg(REG_MAGIC, 32'hFFFF_FFFF);
                write_reg(REG_VERSION, 32'd255);
                write_reg(REG_TYPE_LO, 32'd0);
                write_reg(REG_TYPE_HI, 32'd255);
                write_reg(REG_MAX_FRAME, 32'hFFFF_FFFF);
            end
            3:
            begin
                write_reg(REG_MAGIC, 32'd0);
                write_reg(REG_VERSION, 32'd0);
                write_reg(REG_TYPE_LO, 32'd255);
                write_reg(REG_MAX_FRAME, 32'd40);
            end
            4:
            begin
                // empty type window
                write_reg(REG_TYPE_LO, 32'd200);
                write_reg(REG_TYPE_HI, 32'd10);
                write_reg(REG_MAX_FRAME, 32'd4096);
            end
            5:
            begin
                write_reg(REG_TYPE_LO, 32'd1);
                write_reg(REG_TYPE_HI, 32'd1);
                write_reg(REG_VERSION, $urandom_range(0, 255));
                write_reg(REG_MAX_FRAME, 32'd0);
            end
            6:
            begin
                write_reg(REG_TYPE_LO, 32'd0);
                write_reg(REG_TYPE_HI, 32'd0);
                write_reg(REG_MAX_FRAME, 32'd14);
            end
            default:
            begin
                write_reg(REG_MAGIC, $urandom);
                write_reg(REG_VERSION, $urandom_range(0, 255));
                write_reg(REG_TYPE_LO, $urandom_range(0, 40));
                write_reg(REG_TYPE_HI, $urandom_range(41, 255));
                write_reg(REG_MAX_FRAME, $urandom_range(60, 4096));
            end
        endcase
        wr_en <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int unsigned run;
        int unsigned gap;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 12);
            res_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = idle_len();
            if (gap != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_beat(res_ch.item_kind, res_ch.payload_byte, res_ch.frame_status,
                          res_ch.message_type, res_ch.payload_length);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int          phase;
        int unsigned sent;
        rst_n <= 1'b0;
        rx_ch.valid <= 1'b0;
        rx_ch.data_byte <= 8'd0;
        rx_ch.end_of_buffer <= 1'b0;
        wr_en <= 1'b0;
        wr_index <= REG_MAGIC;
        wr_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte buffers, then the smallest legal frame at the top type
        frame_bytes = '{8'h00};
        send_buffer();
        frame_bytes = '{8'hFF};
        send_buffer();
        frame_bytes.delete();
        put_header(sb.cfg.magic, sb.cfg.version, 8'hFF, 32'd0);
        put_crc();
        send_buffer();

        for (phase = 0; phase < 8; phase++)
        begin
            if (phase != 0)
            begin
                drain();
                repeat (3) @(posedge clk);
                set_phase(phase);
            end
            sent = 0;
            while (sent < 70)
            begin
                make_buffer();
                send_buffer();
                sent += frame_bytes.size();
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
